// ===== hw/rtl/pcscd_pkg.sv =====
// ----------------------------------------------------------------------------
// pcscd_pkg
// Shared types and constants of the page cache second-chance directory.
// ----------------------------------------------------------------------------
package pcscd_pkg;

   localparam int CACHE_SLOTS = 64;
   localparam int PAGE_BYTES  = 4096;
   localparam int SLOT_W      = $clog2(CACHE_SLOTS);
   localparam int OFS_W       = $clog2(PAGE_BYTES);
   localparam int FILE_W      = 10;
   localparam int BYTE_W      = 40;
   localparam int PAGE_W      = BYTE_W - OFS_W;
   localparam int EVPG_W      = 28;
   // tag entry: valid, file, page, touched
   localparam int TAG_W       = 2 + FILE_W + PAGE_W;
   localparam int LINK_W      = 2 * SLOT_W;

   typedef struct packed {
      logic [FILE_W-1:0] file_id;
      logic [BYTE_W-1:0] byte_offset;
   } req_type;

   typedef struct packed {
      logic              hit;
      logic [5:0]        slot;
      logic [11:0]       in_page_offset;
      logic              evicted_valid;
      logic [FILE_W-1:0] evicted_file;
      logic [EVPG_W-1:0] evicted_page;
   } rsp_type;

   typedef struct packed {
      logic              valid;
      logic [FILE_W-1:0] file;
      logic [PAGE_W-1:0] page;
      logic              touched;
   } tag_type;

   typedef struct packed {
      logic [SLOT_W-1:0] next;
      logic [SLOT_W-1:0] prev;
   } link_type;

endpackage

// ===== hw/rtl/pcscd_ram.sv =====
// ----------------------------------------------------------------------------
// pcscd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pcscd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// ===== hw/rtl/page_cache_second_chance_directory.sv =====
// ----------------------------------------------------------------------------
// page_cache_second_chance_directory
// Page cache directory: tag lookup, second-chance recency list, eviction.
// ----------------------------------------------------------------------------
// Usage:
//  req_ carries one access (file id, byte offset); rsp_ returns one result
//  per access: hit flag, slot, in-page offset and the displaced tag.
//  After reset a clearing pass over every slot writes invalid tags and
//  the slot-order list into the memories; req_stall is high meanwhile.
//  One access is worked on at a time. The tag memory (tags and touched
//  bits) is scanned one slot per cycle, every slot in turn. Then a hit
//  marks its slot touched; a miss moves each touched tail to the head,
//  clearing its touched bit, at most CACHE_SLOTS moves, then writes the
//  new tag over the tail and relinks that slot as the head. The next
//  access is taken once the result leaves the sequencer.
//  The result sits in an output register; while rsp_stall is high it
//  holds, the next access is still taken and worked on, and its result
//  waits inside with req_stall high until the register frees up.
// ----------------------------------------------------------------------------
module page_cache_second_chance_directory (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  pcscd_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output pcscd_pkg::rsp_type rsp_data
);
   import pcscd_pkg::*;

   typedef enum logic [9:0] {
      ST_INIT  = 10'b0000000001,
      ST_IDLE  = 10'b0000000010,
      ST_SCAN  = 10'b0000000100,
      ST_TAIL  = 10'b0000001000,
      ST_TLNK  = 10'b0000010000,
      ST_ROT   = 10'b0000100000,
      ST_ROT2  = 10'b0001000000,
      ST_EVW   = 10'b0010000000,
      ST_EVW2  = 10'b0100000000,
      ST_OUT   = 10'b1000000000
   } state_type;

   state_type         state_ff, state_in;
   logic [SLOT_W:0]   cnt_ff, cnt_in;
   logic [SLOT_W:0]   guard_ff, guard_in;
   logic [SLOT_W-1:0] head_ff, head_in, tail_ff, tail_in;
   req_type           req_ff, req_in;
   logic              found_ff, found_in;
   logic [SLOT_W-1:0] hslot_ff, hslot_in;
   link_type          tlnk_ff, tlnk_in;
   rsp_type           res_ff, res_in;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_v_ff, rsp_v_in;

   logic              tag_we;
   logic [SLOT_W-1:0] tag_wa, tag_ra;
   tag_type           tag_wd, tag_rd;
   logic              lnk_we;
   logic [SLOT_W-1:0] lnk_wa, lnk_ra;
   link_type          lnk_wd, lnk_rd;
   logic [PAGE_W-1:0] req_page;
   logic [SLOT_W-1:0] cnt_slot, prev_slot;

   pcscd_ram #(.WIDTH(TAG_W), .DEPTH(CACHE_SLOTS)) u_tag_ram (
      .clock(clock), .wr_en(tag_we), .wr_addr(tag_wa), .wr_data(tag_wd),
      .rd_addr(tag_ra), .rd_data(tag_rd));

   pcscd_ram #(.WIDTH(LINK_W), .DEPTH(CACHE_SLOTS)) u_link_ram (
      .clock(clock), .wr_en(lnk_we), .wr_addr(lnk_wa), .wr_data(lnk_wd),
      .rd_addr(lnk_ra), .rd_data(lnk_rd));

   assign req_page  = req_ff.byte_offset[BYTE_W-1:OFS_W];
   assign cnt_slot  = cnt_ff[SLOT_W-1:0];
   assign prev_slot = cnt_slot - SLOT_W'(1);
   assign req_stall = !(state_ff == ST_IDLE);
   assign rsp_valid = rsp_v_ff;
   assign rsp_data  = rsp_ff;

   // sequencer
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      guard_in = guard_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      req_in   = req_ff;
      found_in = found_ff;
      hslot_in = hslot_ff;
      tlnk_in  = tlnk_ff;
      res_in   = res_ff;
      rsp_in   = rsp_ff;
      rsp_v_in = rsp_v_ff && rsp_stall;
      tag_we   = 1'b0;
      tag_wa   = cnt_slot;
      tag_wd   = '0;
      tag_ra   = cnt_slot;
      lnk_we   = 1'b0;
      lnk_wa   = cnt_slot;
      lnk_wd   = '0;
      lnk_ra   = tail_ff;
      case (state_ff)
         ST_INIT: begin
            tag_we      = 1'b1;
            lnk_we      = 1'b1;
            lnk_wd.next = cnt_slot + SLOT_W'(1);
            lnk_wd.prev = prev_slot;
            cnt_in      = cnt_ff + 1'b1;
            if (cnt_slot == SLOT_W'(CACHE_SLOTS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid && !req_stall) begin
               req_in   = req_data;
               found_in = 1'b0;
               cnt_in   = '0;
               state_in = ST_SCAN;
            end
         end
         // one slot read per cycle; compare the one read last cycle
         ST_SCAN: begin
            tag_ra = cnt_slot;
            if (cnt_ff != '0 && !found_ff && tag_rd.valid &&
                tag_rd.file == req_ff.file_id && tag_rd.page == req_page) begin
               found_in = 1'b1;
               hslot_in = prev_slot;
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == (SLOT_W+1)'(CACHE_SLOTS)) begin
               guard_in = '0;
               state_in = ST_TAIL;
            end
         end
         // hit: mark touched; miss: read the tail's tag and links
         ST_TAIL: begin
            res_in.in_page_offset = req_ff.byte_offset[OFS_W-1:0];
            res_in.evicted_valid  = 1'b0;
            res_in.evicted_file   = '0;
            res_in.evicted_page   = '0;
            if (found_ff) begin
               tag_we         = 1'b1;
               tag_wa         = hslot_ff;
               tag_wd.valid   = 1'b1;
               tag_wd.file    = req_ff.file_id;
               tag_wd.page    = req_page;
               tag_wd.touched = 1'b1;
               res_in.hit     = 1'b1;
               res_in.slot    = hslot_ff;
               state_in       = ST_OUT;
            end else begin
               tag_ra   = tail_ff;
               lnk_ra   = tail_ff;
               state_in = ST_TLNK;
            end
         end
         // touched tail gets a second chance until CACHE_SLOTS moves, else it is evicted
         ST_TLNK: begin
            tlnk_in = lnk_rd;
            lnk_ra  = head_ff;
            if (tag_rd.touched && guard_ff != (SLOT_W+1)'(CACHE_SLOTS)) begin
               tag_we         = 1'b1;
               tag_wa         = tail_ff;
               tag_wd         = tag_rd;
               tag_wd.touched = 1'b0;
               guard_in       = guard_ff + 1'b1;
               state_in       = (tail_ff == head_ff) ? ST_TAIL : ST_ROT;
            end else begin
               res_in.hit  = 1'b0;
               res_in.slot = tail_ff;
               if (tag_rd.valid) begin
                  res_in.evicted_valid = 1'b1;
                  res_in.evicted_file  = tag_rd.file;
                  res_in.evicted_page  = tag_rd.page[EVPG_W-1:0];
               end
               tag_we         = 1'b1;
               tag_wa         = tail_ff;
               tag_wd.valid   = 1'b1;
               tag_wd.file    = req_ff.file_id;
               tag_wd.page    = req_page;
               tag_wd.touched = 1'b1;
               state_in       = (tail_ff == head_ff) ? ST_OUT : ST_EVW;
            end
         end
         // rotate tail to head: next[t]=head, prev[head]=t
         ST_ROT: begin
            lnk_we      = 1'b1;
            lnk_wa      = tail_ff;
            lnk_wd.next = head_ff;
            lnk_wd.prev = tlnk_ff.prev;
            tlnk_in     = lnk_rd;
            state_in    = ST_ROT2;
         end
         ST_ROT2: begin
            lnk_we      = 1'b1;
            lnk_wa      = head_ff;
            lnk_wd.next = tlnk_ff.next;
            lnk_wd.prev = tail_ff;
            head_in     = tail_ff;
            tail_in     = lnk_rd.prev;
            state_in    = ST_TAIL;
         end
         ST_EVW: begin
            lnk_we      = 1'b1;
            lnk_wa      = tail_ff;
            lnk_wd.next = head_ff;
            lnk_wd.prev = tlnk_ff.prev;
            tlnk_in     = lnk_rd;
            state_in    = ST_EVW2;
         end
         ST_EVW2: begin
            lnk_we      = 1'b1;
            lnk_wa      = head_ff;
            lnk_wd.next = tlnk_ff.next;
            lnk_wd.prev = tail_ff;
            head_in     = tail_ff;
            tail_in     = lnk_rd.prev;
            state_in    = ST_OUT;
         end
         // hand the result to the output register once it is free
         ST_OUT: begin
            if (!rsp_v_ff || !rsp_stall) begin
               rsp_in   = res_ff;
               rsp_v_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         cnt_ff   <= '0;
         guard_ff <= '0;
         head_ff  <= '0;
         tail_ff  <= SLOT_W'(CACHE_SLOTS - 1);
         found_ff <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         guard_ff <= guard_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         found_ff <= found_in;
         rsp_v_ff <= rsp_v_in;
      end
      req_ff   <= req_in;
      hslot_ff <= hslot_in;
      tlnk_ff  <= tlnk_in;
      res_ff   <= res_in;
      rsp_ff   <= rsp_in;
   end
endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the page cache second-chance directory: drives
// accesses with random gaps, predicts each result with a behavioral copy of
// the tag store and recency list, and checks every result in order.
// ----------------------------------------------------------------------------
module tb_top;
   import pcscd_pkg::*;

   localparam int NUM_RANDOM = 930;
   localparam int CYCLE_LIMIT = 1500000;

   // Scoreboard: behavioral directory plus a queue of predicted results
   class dir_scoreboard;
      bit           vld [CACHE_SLOTS];
      bit [9:0]     tfile [CACHE_SLOTS];
      bit [27:0]    tpage [CACHE_SLOTS];
      bit           touch [CACHE_SLOTS];
      bit [5:0]     nxt [CACHE_SLOTS];
      bit [5:0]     prv [CACHE_SLOTS];
      bit [5:0]     head, tail;
      rsp_type      pending[$];
      int           errors;

      function new();
         for (int i = 0; i < CACHE_SLOTS; i++) begin
            vld[i] = 0; tfile[i] = 0; tpage[i] = 0; touch[i] = 0;
            nxt[i] = 6'(i + 1);
            prv[i] = 6'(i + CACHE_SLOTS - 1);
         end
         head = 0;
         tail = 6'(CACHE_SLOTS - 1);
         errors = 0;
      endfunction

      function void tail_to_head();
         bit [5:0] t;
         t = tail;
         if (t != head) begin
            tail = prv[t];
            nxt[t] = head;
            prv[head] = t;
            head = t;
         end
      endfunction

      // predict the result of one accepted access
      function void note_access(req_type rq);
         rsp_type  r;
         bit [27:0] pg;
         bit       found;
         bit [5:0] s;
         found = 0;
         s = 0;
         pg = rq.byte_offset[39:12];
         for (int i = 0; i < CACHE_SLOTS; i++)
            if (!found && vld[i] && tfile[i] == rq.file_id && tpage[i] == pg) begin
               found = 1;
               s = 6'(i);
            end
         r = '0;
         r.hit = found;
         r.in_page_offset = rq.byte_offset[11:0];
         if (found) begin
            touch[s] = 1;
         end else begin
            // second chance: touched tails go back to the head
            for (int g = 0; g < CACHE_SLOTS && touch[tail]; g++) begin
               touch[tail] = 0;
               tail_to_head();
            end
            s = tail;
            if (vld[s]) begin
               r.evicted_valid = 1;
               r.evicted_file = tfile[s];
               r.evicted_page = tpage[s];
            end
            tail_to_head();
            vld[s] = 1; tfile[s] = rq.file_id; tpage[s] = pg; touch[s] = 1;
         end
         r.slot = s;
         pending.push_back(r);
      endfunction

      function void check_result(rsp_type act);
         rsp_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result %p", $time, act);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (e.hit != act.hit)
            $display("%0t: hit exp %0d act %0d", $time, e.hit, act.hit);
         if (e.slot != act.slot)
            $display("%0t: slot exp %0d act %0d", $time, e.slot, act.slot);
         if (e.in_page_offset != act.in_page_offset)
            $display("%0t: in_page_offset exp %h act %h", $time,
                     e.in_page_offset, act.in_page_offset);
         if (e.evicted_valid != act.evicted_valid)
            $display("%0t: evicted_valid exp %0d act %0d", $time,
                     e.evicted_valid, act.evicted_valid);
         if (e.evicted_file != act.evicted_file)
            $display("%0t: evicted_file exp %h act %h", $time,
                     e.evicted_file, act.evicted_file);
         if (e.evicted_page != act.evicted_page)
            $display("%0t: evicted_page exp %h act %h", $time,
                     e.evicted_page, act.evicted_page);
         if (e != act) errors++;
      endfunction
   endclass

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 0;
   rsp_type rsp_data;

   dir_scoreboard sb = new();
   bit      drive_done = 0;
   bit      calm = 0;       // stretch with no idling
   bit      hold_off = 0;   // long receiver stall
   int      cycles = 0;

   page_cache_second_chance_directory uut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // sample on the rising edge
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && req_valid && !req_stall) sb.note_access(req_data);
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_data);
      if (cycles > CYCLE_LIMIT) begin
         $display("page_cache_second_chance_directory regression: fail");
         $finish;
      end
   end

   // receiver stall, driven on the falling edge
   always @(negedge clock)
      rsp_stall <= hold_off || (!calm && $urandom_range(99) < 7);

   // small working set so hits and touched walks are common
   function automatic req_type pick_access();
      req_type r;
      r.byte_offset = 40'({$urandom, $urandom});
      r.file_id = 10'($urandom);
      case ($urandom_range(9))
         0, 1, 2, 3, 4: begin
            r.file_id = 10'($urandom_range(3));
            r.byte_offset[39:12] = 28'($urandom_range(23));
         end
         5, 6: begin
            r.file_id = 10'($urandom_range(1));
            r.byte_offset[39:12] = 28'($urandom_range(90));
         end
         default: ;
      endcase
      return r;
   endfunction

   // one transaction, idle gaps before it; called at a falling edge
   task automatic send_access(req_type r);
      while (!calm && $urandom_range(99) < 7) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      req_type r;
      repeat (9) @(negedge clock);
      reset <= 0;

      // directed: extremes, hits, a run of misses from one file
      send_access('{file_id: 10'h3FF, byte_offset: 40'hFF_FFFF_FFFF});
      send_access('{file_id: 10'h000, byte_offset: 40'h0});
      send_access('{file_id: 10'h3FF, byte_offset: 40'hFF_FFFF_F000});
      send_access('{file_id: 10'h000, byte_offset: 40'h0_0000_0FFF});
      send_access('{file_id: 10'h2AA, byte_offset: 40'hAA_AAAA_AAAA});
      send_access('{file_id: 10'h155, byte_offset: 40'h55_5555_5555});
      for (int i = 0; i < 19; i++) begin
         r.file_id = 10'd7;
         r.byte_offset = {28'(i), 12'(i * 37)};
         send_access(r);
      end

      calm = 1;
      for (int i = 0; i < NUM_RANDOM; i++) begin
         if (i == 300) calm = 0;
         if (i == 500) fork
            begin hold_off = 1; repeat (400) @(negedge clock); hold_off = 0; end
         join_none
         send_access(pick_access());
      end
      req_valid <= 0;
      drive_done = 1;
   end

   initial begin
      wait (drive_done);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("page_cache_second_chance_directory regression: pass");
      else
         $display("page_cache_second_chance_directory regression: fail");
      $finish;
   end
endmodule
